/* src/ofb_pkg.sv */
// ----------------------------------------------------------------------------
// ofb_pkg
// Shared types and codes for the overwriting byte FIFO with search.
// ----------------------------------------------------------------------------
`default_nettype none

package ofb_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned OP_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_FIND   = 2'd3
	} op_t;

	// one result word
	typedef struct packed {
		logic [COUNT_W-1:0] match_index;
		logic               match_found;
		logic [COUNT_W-1:0] fill_level;
	} result_t;

	// search engine completion
	typedef struct packed {
		logic               valid;
		logic               found;
		logic [COUNT_W-1:0] index;
	} done_t;

endpackage

`default_nettype wire

/* src/ofb_in_if.sv */
// ----------------------------------------------------------------------------
// ofb_in_if
// Command channel: operation, byte and remove count with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ofb_in_if;

	logic                         valid;
	logic                         ready;
	logic [ofb_pkg::OP_W-1:0]     operation;
	logic [ofb_pkg::BYTE_W-1:0]   byte_value;
	logic [ofb_pkg::COUNT_W-1:0]  remove_count;

	modport source (output valid, output operation, output byte_value,
		output remove_count, input ready);
	modport sink (input valid, input operation, input byte_value,
		input remove_count, output ready);

endinterface

`default_nettype wire

/* src/ofb_out_if.sv */
// ----------------------------------------------------------------------------
// ofb_out_if
// Result channel: match index, match flag and fill level with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ofb_out_if;

	logic                         valid;
	logic                         ready;
	logic [ofb_pkg::COUNT_W-1:0]  match_index;
	logic                         match_found;
	logic [ofb_pkg::COUNT_W-1:0]  fill_level;

	modport source (output valid, output match_index, output match_found,
		output fill_level, input ready);
	modport sink (input valid, input match_index, input match_found,
		input fill_level, output ready);

endinterface

`default_nettype wire

/* src/ofb_ram.sv */
// ----------------------------------------------------------------------------
// ofb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/ofb_search.sv */
// ----------------------------------------------------------------------------
// ofb_search
// Find engine: walks the ring from the oldest byte, one RAM read per cycle,
// and compares each returned byte against the search value.
// ----------------------------------------------------------------------------
`default_nettype none

module ofb_search #(
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [ofb_pkg::BYTE_W-1:0]           start_value,
	input  wire logic [$clog2(DEPTH)-1:0]             start_head,
	input  wire logic [$clog2(DEPTH+1)-1:0]           start_fill,
	output      logic                                 rd_en,
	output      logic [$clog2(DEPTH)-1:0]             rd_addr,
	input  wire logic [ofb_pkg::BYTE_W-1:0]           rd_data,
	output      logic                                 busy,
	output      ofb_pkg::done_t                       done
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned MW = (CW > ofb_pkg::COUNT_W) ? CW : ofb_pkg::COUNT_W;

	logic                        busy_q;
	logic [CW-1:0]               rd_idx_q;
	logic [AW-1:0]               rd_addr_q;
	logic [CW-1:0]               fill_q;
	logic [ofb_pkg::BYTE_W-1:0]  value_q;
	logic                        cmp_valid_s1;
	logic [CW-1:0]               cmp_idx_s1;
	logic                        hit;
	logic                        last;
	logic [MW-1:0]               idx_ext;
	logic [MW-1:0]               fill_ext;

	assign rd_en   = busy_q && (rd_idx_q < fill_q);
	assign rd_addr = rd_addr_q;
	assign busy    = busy_q;

	assign hit      = cmp_valid_s1 && (rd_data == value_q);
	assign last     = cmp_valid_s1 && (cmp_idx_s1 == fill_q - CW'(1));
	assign idx_ext  = MW'(cmp_idx_s1);
	assign fill_ext = MW'(fill_q);

	always_comb begin
		done.valid = hit || last;
		done.found = hit;
		done.index = hit ? idx_ext[ofb_pkg::COUNT_W-1:0] : fill_ext[ofb_pkg::COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cmp_valid_s1 <= 1'b0;
		end else if (start) begin
			busy_q       <= 1'b1;
			cmp_valid_s1 <= 1'b0;
		end else if (done.valid) begin
			// drop the read still in flight
			busy_q       <= 1'b0;
			cmp_valid_s1 <= 1'b0;
		end else begin
			cmp_valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rd_idx_q  <= '0;
			rd_addr_q <= start_head;
			fill_q    <= start_fill;
			value_q   <= start_value;
		end else if (rd_en) begin
			rd_idx_q   <= rd_idx_q + CW'(1);
			rd_addr_q  <= (rd_addr_q == AW'(DEPTH - 1)) ? '0 : rd_addr_q + AW'(1);
		end
		cmp_idx_s1 <= rd_idx_q;
	end

endmodule

`default_nettype wire

/* src/overwriting_byte_fifo_with_search_core.sv */
// ----------------------------------------------------------------------------
// overwriting_byte_fifo_with_search_core
// Byte ring buffer that overwrites its oldest byte when full, with a
// find-first-match search over the stored bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word per handshake: append a byte, remove up to
//   remove_count bytes from the front, clear, or find a byte. rsp returns one
//   result word per command with the fill level after the command and, for
//   find, the position of the first match counted from the oldest byte (or
//   the fill level and match_found low when there is none).
//   For append, remove, clear and a find on an empty buffer, the result is
//   registered at the edge that accepts the command. A find walks the stored
//   bytes from the oldest until a hit or the newest byte, one byte compared per
//   cycle through the single RAM read port.
//   req.ready is low while a find runs. A two-word output stage (output
//   register plus skid) lets one command be accepted while a result waits;
//   with both words full, req.ready drops until rsp takes a word.
//   Reset empties the buffer and the output stage and zeroes the head. The
//   byte store itself is not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_byte_fifo_with_search_core #(
	parameter int unsigned DEPTH = 256
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ofb_in_if.sink      req,
	ofb_out_if.source   rsp
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned CNT_W = ofb_pkg::COUNT_W;
	localparam int unsigned MW = (CW > CNT_W) ? CW : CNT_W;
	localparam int unsigned SW = ((AW > CNT_W) ? AW : CNT_W) + 1;

	logic [AW-1:0]               head_q;
	logic [CW-1:0]               fill_q;
	logic [AW-1:0]               head_nxt;
	logic [CW-1:0]               fill_nxt;

	logic                        out_valid_q;
	ofb_pkg::result_t            out_q;
	logic                        skid_valid_q;
	ofb_pkg::result_t            skid_q;

	logic                        accept;
	logic                        search_busy;
	ofb_pkg::done_t              search_done;
	logic                        search_start;
	logic                        res_valid;
	ofb_pkg::result_t            res;

	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [ofb_pkg::BYTE_W-1:0]  rd_data;

	logic [MW-1:0]               fill_nxt_ext;
	logic [MW-1:0]               fill_cur_ext;

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
		input logic [SW-1:0] offset);
		logic [SW-1:0] sum;
		sum = SW'(base) + offset;
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign req.ready = !search_busy && !skid_valid_q;
	assign accept    = req.valid && req.ready;

	// next head/fill, RAM write and search start for an accepted command
	always_comb begin
		head_nxt     = head_q;
		fill_nxt     = fill_q;
		wr_en        = 1'b0;
		wr_addr      = ring_add(head_q, SW'(fill_q));
		search_start = 1'b0;
		case (ofb_pkg::op_t'(req.operation))
			ofb_pkg::OP_APPEND: begin
				wr_en = accept;
				if (fill_q == CW'(DEPTH)) begin
					wr_addr  = head_q;
					head_nxt = ring_add(head_q, SW'(1));
				end else begin
					fill_nxt = fill_q + CW'(1);
				end
			end
			ofb_pkg::OP_REMOVE: begin
				if (MW'(req.remove_count) >= MW'(fill_q)) begin
					fill_nxt = '0;
				end else begin
					head_nxt = ring_add(head_q, SW'(req.remove_count));
					fill_nxt = fill_q - CW'(req.remove_count);
				end
			end
			ofb_pkg::OP_CLEAR: begin
				fill_nxt = '0;
			end
			ofb_pkg::OP_FIND: begin
				search_start = accept && (fill_q != '0);
			end
			default: begin
				fill_nxt = fill_q;
			end
		endcase
	end

	assign fill_nxt_ext = MW'(fill_nxt);
	assign fill_cur_ext = MW'(fill_q);

	// a result comes from an immediate command or from the search engine
	always_comb begin
		if (search_done.valid) begin
			res_valid       = 1'b1;
			res.match_index = search_done.index;
			res.match_found = search_done.found;
			res.fill_level  = fill_cur_ext[CNT_W-1:0];
		end else begin
			res_valid       = accept && !search_start;
			res.match_index = '0;
			res.match_found = 1'b0;
			res.fill_level  = fill_nxt_ext[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			head_q <= head_nxt;
			fill_q <= fill_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && rsp.ready) begin
			// advance the skid word, or take a new result straight in
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			// skid is always empty here: no command is taken while it holds a word
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && rsp.ready && skid_valid_q) begin
			out_q <= skid_q;
		end else if (res_valid && (!out_valid_q || rsp.ready)) begin
			out_q <= res;
		end
		if (res_valid && out_valid_q && !rsp.ready) begin
			skid_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.match_index = out_q.match_index;
	assign rsp.match_found = out_q.match_found;
	assign rsp.fill_level  = out_q.fill_level;

	ofb_search #(
		.DEPTH (DEPTH)
	) u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (search_start),
		.start_value (req.byte_value),
		.start_head  (head_q),
		.start_fill  (fill_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.busy        (search_busy),
		.done        (search_done)
	);

	ofb_ram #(
		.WIDTH (ofb_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (req.byte_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	a_busy_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		search_busy |-> !req.ready)
		else $error("command accepted during a find");

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a word while the output register is empty");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		search_done.valid |-> (search_busy && !skid_valid_q))
		else $error("find result outside a running search");

endmodule

`default_nettype wire
